### rtl/core/rtpi_pkg.sv
`timescale 1ns / 1ps
// rtpi_pkg: shared types, constants and helpers for the palette plotter core
// no dependencies

package rtpi_pkg;

  localparam int unsigned DIM_W   = 13;  // configuration dimension width
  localparam int unsigned POS_W   = 12;  // pixel / screen coordinate width
  localparam int unsigned LVL_W   = 16;  // channel level width
  localparam int unsigned IDX_W   = 8;   // palette index width
  localparam int unsigned FRAC_BITS = 12;
  localparam int unsigned QSHIFT  = FRAC_BITS - 8;
  localparam int unsigned QROUND  = (1 << QSHIFT) >> 1;
  localparam int unsigned LEVEL_MAX = 255;
  localparam int unsigned DIV_NW  = POS_W + DIM_W;  // dividend width
  localparam int unsigned DIV_DW  = DIM_W;          // divisor width
  localparam int unsigned DIV_CW  = $clog2(DIV_NW);
  localparam int unsigned LUMA_DEN = 100 << QSHIFT;
  // luma divisor is 25 << LUMA_SHIFT: shift, then multiply by a reciprocal of 25
  localparam int unsigned LUMA_SHIFT  = QSHIFT + 2;
  localparam int unsigned LUMA_LIMIT  = (LEVEL_MAX + 1) * LUMA_DEN;  // clamps at or above
  localparam int unsigned RECIP_25    = 5243;  // ceil(2^17 / 25), exact below 6400
  localparam int unsigned RECIP_SHIFT = 17;

  // configuration register indexes
  localparam logic [2:0] REG_GREY_SELECT    = 3'd0;
  localparam logic [2:0] REG_IMAGE_COLUMNS  = 3'd1;
  localparam logic [2:0] REG_IMAGE_ROWS     = 3'd2;
  localparam logic [2:0] REG_SCREEN_COLUMNS = 3'd3;
  localparam logic [2:0] REG_SCREEN_ROWS    = 3'd4;

  typedef struct packed {
    logic             grey;
    logic [DIM_W-1:0] img_cols;
    logic [DIM_W-1:0] img_rows;
    logic [DIM_W-1:0] scr_cols;
    logic [DIM_W-1:0] scr_rows;
  } cfg_t;

  // classified item handed from front to back
  typedef struct packed {
    logic              new_line;
    logic              grey;
    logic              row_scale;
    logic              col_scale;
    logic [POS_W-1:0]  col;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  off_c;
    logic [POS_W-1:0]  off_r;
    logic              idx_div;   // index needs a division
    logic [IDX_W-1:0]  idx_code;  // direct index when no division
    logic [1:0]        hi_bits;   // value and saturation bits for hue codes
    logic [DIV_NW-1:0] idx_num;
    logic [DIV_DW-1:0] idx_den;
  } item_t;

  function automatic logic [7:0] quantize(input logic [LVL_W-1:0] lv);
    logic [LVL_W:0] s;
    logic [LVL_W:0] q;
    s = {1'b0, lv} + (LVL_W+1)'(QROUND);
    q = s >> QSHIFT;
    quantize = (q > (LVL_W+1)'(LEVEL_MAX)) ? 8'(LEVEL_MAX) : q[7:0];
  endfunction

endpackage

### rtl/core/rtpi_front.sv
`timescale 1ns / 1ps
// rtpi_front: classifies an incoming pixel into a work item for the back end
// depends on rtpi_pkg

module rtpi_front (
  input  rtpi_pkg::cfg_t                    cfg,
  input  logic [rtpi_pkg::POS_W-1:0]        pixel_col,
  input  logic [rtpi_pkg::POS_W-1:0]        pixel_row,
  input  logic [rtpi_pkg::LVL_W-1:0]        red_level,
  input  logic [rtpi_pkg::LVL_W-1:0]        green_level,
  input  logic [rtpi_pkg::LVL_W-1:0]        blue_level,
  output rtpi_pkg::item_t                   item
);
  import rtpi_pkg::*;

  logic [7:0]        qr, qg, qb, mx, mn, d;
  logic [10:0]       d5, t;
  logic [9:0]        d3;
  logic              low_sat;
  logic [IDX_W-1:0]  grey_code;
  logic [23:0]       luma_num;
  logic [DIM_W-1:0]  diff_r, diff_c;

  always_comb begin
    qr = quantize(red_level);
    qg = quantize(green_level);
    qb = quantize(blue_level);
    mx = qr;
    if (qg > mx) mx = qg;
    if (qb > mx) mx = qb;
    mn = qr;
    if (qg < mn) mn = qg;
    if (qb < mn) mn = qb;
    d  = mx - mn;
    d5 = 11'(d) * 11'd5;
    d3 = 10'(d) * 10'd3;
    low_sat = (d5 < 11'(mx)) || (d == 8'd0);

    // weak saturation: one of four greys by value
    if ((10'(mx) << 2) < 10'd255)       grey_code = 8'h00;
    else if ((11'(mx) * 11'd5) > 11'd1020) grey_code = 8'h40;
    else if ((9'(mx) << 1) > 9'd255)    grey_code = 8'hC0;
    else                                grey_code = 8'h80;

    // hue sector value times d; blue max wins ties, then green
    if (qb == mx) begin
      if (qr == mn) t = 11'(d3) + 11'(mx - qg);
      else          t = d5 - 11'(mx - qr);
    end else if (qg == mx) begin
      if (qb == mn) t = 11'(d) + 11'(mx - qr);
      else          t = 11'(d3) - 11'(mx - qb);
    end else begin
      if (qg == mn) t = d5 + 11'(mx - qb);
      else          t = 11'(d) - 11'(mx - qg);
    end

    luma_num = 24'(red_level) * 24'd30 + 24'(green_level) * 24'd51
             + 24'(blue_level) * 24'd19;

    diff_r = cfg.scr_rows - cfg.img_rows;
    diff_c = cfg.scr_cols - cfg.img_cols;

    item.new_line  = (pixel_col == '0);
    item.grey      = cfg.grey;
    item.row_scale = cfg.img_rows > cfg.scr_rows;
    item.col_scale = cfg.img_cols > cfg.scr_cols;
    item.col       = pixel_col;
    item.row       = pixel_row;
    item.off_r     = item.row_scale ? '0 : diff_r[DIM_W-1:1];
    item.off_c     = item.col_scale ? '0 : diff_c[DIM_W-1:1];
    item.idx_div   = !cfg.grey && !low_sat;
    item.idx_code  = grey_code;
    item.hi_bits   = {((9'(mx) << 1) > 9'd255), ((9'(d) << 1) > 9'(mx))};
    if (cfg.grey) begin
      // luma sum plus half the divisor, divided in the back end
      item.idx_num = DIV_NW'(luma_num) + DIV_NW'(LUMA_DEN / 2);
      item.idx_den = '0;
    end else begin
      item.idx_num = DIV_NW'({t, 5'b0});
      item.idx_den = DIV_DW'(d3);
    end
  end

endmodule

### rtl/core/rtpi_queue.sv
`timescale 1ns / 1ps
// rtpi_queue: two-entry item queue between front and back
// depends on rtpi_pkg

module rtpi_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  rtpi_pkg::item_t wr_item,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output rtpi_pkg::item_t rd_item
);
  import rtpi_pkg::*;

  item_t      mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push, do_pop;

  assign full    = count_r == 2'd2;
  assign empty   = count_r == 2'd0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_item = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wr_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)  rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

### rtl/core/rtpi_div.sv
`timescale 1ns / 1ps
// rtpi_div: shared restoring divider, one quotient bit per cycle
// depends on rtpi_pkg

module rtpi_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [rtpi_pkg::DIV_NW-1:0]   num,
  input  logic [rtpi_pkg::DIV_DW-1:0]   den,
  output logic                          done,
  output logic [rtpi_pkg::DIV_NW-1:0]   quo
);
  import rtpi_pkg::*;

  logic              busy_r, done_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [DIV_DW-1:0] rem_r, den_r;
  logic [DIV_NW-1:0] quo_r;
  logic [DIV_DW:0]   trial;
  logic              fits;

  assign trial = {rem_r, quo_r[DIV_NW-1]};
  assign fits  = trial >= {1'b0, den_r};
  assign done  = done_r;
  assign quo   = quo_r;

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= fits ? DIV_DW'(trial - {1'b0, den_r}) : trial[DIV_DW-1:0];
      quo_r <= {quo_r[DIV_NW-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + DIV_CW'(1);
        if (cnt_r == DIV_CW'(DIV_NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/core/rtpi_back.sv
`timescale 1ns / 1ps
// rtpi_back: sequencer for scaling, drop decisions, index division and output
// depends on rtpi_pkg, rtpi_div

module rtpi_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rtpi_pkg::cfg_t                cfg,
  input  logic                          q_empty,
  input  rtpi_pkg::item_t               q_item,
  output logic                          q_pop,
  input  logic                          out_pop,
  output logic                          out_empty,
  output logic [rtpi_pkg::POS_W-1:0]    screen_col,
  output logic [rtpi_pkg::POS_W-1:0]    screen_row,
  output logic [rtpi_pkg::IDX_W-1:0]    palette_index
);
  import rtpi_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ROW  = 5'b00010,
    S_COL  = 5'b00100,
    S_IDX  = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t             state_r;
  item_t              it_r;
  logic               dbusy_r;
  logic signed [DIM_W-1:0] prev_col_r, row_floor_r, last_row_r;
  logic [POS_W-1:0]   xs_r, ys_r;
  logic [IDX_W-1:0]   idx_r;
  logic               out_valid_r;
  logic [POS_W-1:0]   out_col_r, out_row_r;
  logic [IDX_W-1:0]   out_idx_r;

  logic               div_start, div_done;
  logic [DIV_NW-1:0]  div_num, div_quo;
  logic [DIV_DW-1:0]  div_den;
  logic signed [DIM_W-1:0] q_s;
  logic [IDX_W-1:0]   idx_calc;
  logic [12:0]        luma_y;
  logic [25:0]        luma_prod;
  logic               slot_free;

  rtpi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign q_pop     = (state_r == S_IDLE) && !q_empty;
  assign out_empty = !out_valid_r;
  assign screen_col    = out_col_r;
  assign screen_row    = out_row_r;
  assign palette_index = out_idx_r;
  assign slot_free = !out_valid_r || out_pop;
  assign q_s       = $signed({1'b0, div_quo[POS_W-1:0]});

  always_comb begin
    div_start = 1'b0;
    div_num   = it_r.idx_num;
    div_den   = it_r.idx_den;
    case (state_r)
      S_ROW: begin
        div_start = it_r.row_scale && !dbusy_r;
        div_num   = DIV_NW'(it_r.row) * DIV_NW'(cfg.scr_rows);
        div_den   = cfg.img_rows;
      end
      S_COL: begin
        div_start = it_r.col_scale && !dbusy_r;
        div_num   = DIV_NW'(it_r.col) * DIV_NW'(cfg.scr_cols);
        div_den   = cfg.img_cols;
      end
      S_IDX: div_start = it_r.idx_div && !dbusy_r;
      default: ;
    endcase
  end

  // final index: luma by reciprocal with clamp, hue quotient folds into 1..63
  always_comb begin
    luma_y    = 13'(it_r.idx_num >> LUMA_SHIFT);
    luma_prod = 26'(luma_y) * 26'(RECIP_25);
    if (it_r.grey) begin
      if (it_r.idx_num >= DIV_NW'(LUMA_LIMIT)) idx_calc = IDX_W'(LEVEL_MAX);
      else                                     idx_calc = luma_prod[RECIP_SHIFT +: IDX_W];
    end else begin
      if (div_quo == '0)             idx_calc = 8'd1;
      else if (div_quo > DIV_NW'(63)) idx_calc = 8'd63;
      else                           idx_calc = div_quo[IDX_W-1:0];
      idx_calc = idx_calc | {it_r.hi_bits, 6'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) it_r <= q_item;
    if (state_r == S_IDLE) begin
      xs_r <= q_item.col;
      ys_r <= q_item.row;
      idx_r <= q_item.idx_code;
    end
    if (state_r == S_ROW && div_done) ys_r <= div_quo[POS_W-1:0];
    if (state_r == S_COL && div_done) xs_r <= div_quo[POS_W-1:0];
    if (state_r == S_IDX && (div_done || it_r.grey)) idx_r <= idx_calc;
    if (state_r == S_EMIT && slot_free) begin
      out_col_r <= it_r.off_c + xs_r;
      out_row_r <= it_r.off_r + ys_r;
      out_idx_r <= idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dbusy_r     <= 1'b0;
      prev_col_r  <= '1;
      row_floor_r <= '1;
      last_row_r  <= '1;
      out_valid_r <= 1'b0;
    end else begin
      // output slot refills as it drains
      if (state_r == S_EMIT && slot_free) out_valid_r <= 1'b1;
      else if (out_pop)                   out_valid_r <= 1'b0;
      if (div_start) dbusy_r <= 1'b1;
      if (div_done)  dbusy_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            if (q_item.new_line) begin
              prev_col_r  <= '1;
              row_floor_r <= last_row_r;
            end
            state_r <= S_ROW;
          end
        end
        S_ROW: begin
          if (!it_r.row_scale) state_r <= S_COL;
          else if (div_done) begin
            if (q_s <= row_floor_r) state_r <= S_IDLE;
            else begin
              last_row_r <= q_s;
              state_r    <= S_COL;
            end
          end
        end
        S_COL: begin
          if (!it_r.col_scale) state_r <= S_IDX;
          else if (div_done) begin
            if (q_s <= prev_col_r) state_r <= S_IDLE;
            else begin
              prev_col_r <= q_s;
              state_r    <= S_IDX;
            end
          end
        end
        S_IDX: begin
          if (!it_r.idx_div || div_done) state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/rgb_to_palette_index_plotter_core.sv
`timescale 1ns / 1ps
// rgb_to_palette_index_plotter_core: top level of the palette plotter
// depends on rtpi_pkg, rtpi_front, rtpi_queue, rtpi_back (with rtpi_div)
// scheduling: row scaling, column scaling and the hue division each run on the
//   shared serial divider; the back end holds one item at a time and takes no
//   new item from the queue until it is through with the last one; a full
//   output register stalls the back end
// reset: synchronous active low; config returns to 640x480 colour mode,
//   line state to none, queue and output register empty

module rgb_to_palette_index_plotter_core (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration writes
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [2:0]                   cfg_index,
  input  logic [rtpi_pkg::DIM_W-1:0]   cfg_data,
  // input items
  input  logic                         in_push,
  output logic                         in_full,
  input  logic [rtpi_pkg::POS_W-1:0]   in_pixel_col,
  input  logic [rtpi_pkg::POS_W-1:0]   in_pixel_row,
  input  logic [rtpi_pkg::LVL_W-1:0]   in_red_level,
  input  logic [rtpi_pkg::LVL_W-1:0]   in_green_level,
  input  logic [rtpi_pkg::LVL_W-1:0]   in_blue_level,
  // result items
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [rtpi_pkg::POS_W-1:0]   out_screen_col,
  output logic [rtpi_pkg::POS_W-1:0]   out_screen_row,
  output logic [rtpi_pkg::IDX_W-1:0]   out_palette_index
);
  import rtpi_pkg::*;

  cfg_t  cfg_r;
  item_t front_item, head_item;
  logic  q_empty, q_pop;

  // config must only be written while idle (the block does not enforce it), so always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grey     <= 1'b0;
      cfg_r.img_cols <= DIM_W'(640);
      cfg_r.img_rows <= DIM_W'(480);
      cfg_r.scr_cols <= DIM_W'(640);
      cfg_r.scr_rows <= DIM_W'(480);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GREY_SELECT:    cfg_r.grey     <= cfg_data[0];
        REG_IMAGE_COLUMNS:  cfg_r.img_cols <= cfg_data;
        REG_IMAGE_ROWS:     cfg_r.img_rows <= cfg_data;
        REG_SCREEN_COLUMNS: cfg_r.scr_cols <= cfg_data;
        REG_SCREEN_ROWS:    cfg_r.scr_rows <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: quantize, hsv / luma prep, scale flags and centring offsets
  rtpi_front u_front (
    .cfg         (cfg_r),
    .pixel_col   (in_pixel_col),
    .pixel_row   (in_pixel_row),
    .red_level   (in_red_level),
    .green_level (in_green_level),
    .blue_level  (in_blue_level),
    .item        (front_item)
  );

  // short queue decouples accept from the serial back end
  rtpi_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .wr_item (front_item),
    .full    (in_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_item (head_item)
  );

  // back: scaling divides, drop of repeated rows / columns, index, output item
  rtpi_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .q_empty       (q_empty),
    .q_item        (head_item),
    .q_pop         (q_pop),
    .out_pop       (out_pop),
    .out_empty     (out_empty),
    .screen_col    (out_screen_col),
    .screen_row    (out_screen_row),
    .palette_index (out_palette_index)
  );

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for rgb_to_palette_index_plotter_core
// depends on rtpi_pkg and the core; predicts plots, checks them in order

module tb;
  import rtpi_pkg::*;

  typedef struct {
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic [IDX_W-1:0] idx;
  } plot_t;

  // predictor of the plotter plus the queue of plots still owed by the core
  class plot_scoreboard;
    logic [DIM_W-1:0] cfg_regs[5];
    int    prev_col, row_floor, kept_row;
    plot_t owed[$];
    int    errors, checked, dropped;

    function void reset_state();
      cfg_regs[REG_GREY_SELECT]    = 0;
      cfg_regs[REG_IMAGE_COLUMNS]  = 640;
      cfg_regs[REG_IMAGE_ROWS]     = 480;
      cfg_regs[REG_SCREEN_COLUMNS] = 640;
      cfg_regs[REG_SCREEN_ROWS]    = 480;
      prev_col = -1; row_floor = -1; kept_row = -1;
    endfunction

    function void write_reg(logic [2:0] ix, logic [DIM_W-1:0] v);
      cfg_regs[ix] = (ix == REG_GREY_SELECT) ? DIM_W'(v[0]) : v;
    endfunction

    static function int level8(logic [LVL_W-1:0] lv);
      int q;
      q = (int'(lv) + QROUND) >> QSHIFT;
      return q > LEVEL_MAX ? LEVEL_MAX : q;
    endfunction

    static function int luma_code(int r, int g, int b);
      int num, den, q;
      num = 30 * r + 51 * g + 19 * b;
      den = 100 << QSHIFT;
      q = (2 * num + den) / (2 * den);
      return q > LEVEL_MAX ? LEVEL_MAX : q;
    endfunction

    static function int hue_code(int r, int g, int b);
      int mx, mn, d, t, c;
      mx = r; mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      d = mx - mn;
      // weak saturation: one of four greys by value
      if (5 * d < mx || d == 0) begin
        if (4 * mx < 255) return 0;
        if (5 * mx > 1020) return 64;
        if (2 * mx > 255) return 192;
        return 128;
      end
      // ties on the max: blue over green over red
      if (b == mx) t = (r == mn) ? 3 * d + (mx - g) : 5 * d - (mx - r);
      else if (g == mx) t = (b == mn) ? d + (mx - r) : 3 * d - (mx - b);
      else t = (g == mn) ? 5 * d + (mx - b) : d - (mx - g);
      if (t < 0) t = 0;
      c = (32 * t) / (3 * d);
      if (c == 0) c = 1;
      if (c > 63) c = 63;
      if (2 * mx > 255) c |= 'h80;
      if (2 * d > mx) c |= 'h40;
      return c;
    endfunction

    function void note_pixel(logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                             logic [LVL_W-1:0] rl, logic [LVL_W-1:0] gl,
                             logic [LVL_W-1:0] bl);
      longint x, y, ic, ir, sc, sr;
      int off_c, off_r, idx;
      plot_t p;
      x = px; y = py; off_c = 0; off_r = 0;
      ic = cfg_regs[REG_IMAGE_COLUMNS]; ir = cfg_regs[REG_IMAGE_ROWS];
      sc = cfg_regs[REG_SCREEN_COLUMNS]; sr = cfg_regs[REG_SCREEN_ROWS];
      if (px == 0) begin
        prev_col = -1;
        row_floor = kept_row;
      end
      if (ir > sr) begin
        y = (y * sr) / ir;
        if (int'(y) <= row_floor) begin dropped++; return; end
        kept_row = int'(y);
      end else off_r = int'((sr - ir) / 2);
      if (ic > sc) begin
        x = (x * sc) / ic;
        if (int'(x) <= prev_col) begin dropped++; return; end
        prev_col = int'(x);
      end else off_c = int'((sc - ic) / 2);
      if (cfg_regs[REG_GREY_SELECT][0]) idx = luma_code(rl, gl, bl);
      else idx = hue_code(level8(rl), level8(gl), level8(bl));
      p.col = POS_W'(off_c + int'(x));
      p.row = POS_W'(off_r + int'(y));
      p.idx = IDX_W'(idx);
      owed.push_back(p);
    endfunction

    task report(string what, int got, int want);
      $display("plot %0d: %s got %0d expected %0d", checked, what, got, want);
      errors++;
    endtask

    task check_plot(logic [POS_W-1:0] c, logic [POS_W-1:0] r,
                    logic [IDX_W-1:0] ix);
      plot_t p;
      if (owed.size() == 0) begin
        report("unexpected plot, col", c, -1);
        return;
      end
      p = owed.pop_front();
      if (c !== p.col) report("screen_col", c, p.col);
      if (r !== p.row) report("screen_row", r, p.row);
      if (ix !== p.idx) report("palette_index", ix, p.idx);
      checked++;
    endtask
  endclass

  logic clk = 0, rst_n = 0;
  logic cfg_valid = 0, cfg_ready;
  logic [2:0] cfg_index = REG_GREY_SELECT;
  logic [DIM_W-1:0] cfg_data = '0;
  logic in_push = 0, in_full;
  logic [POS_W-1:0] in_pixel_col = '0, in_pixel_row = '0;
  logic [LVL_W-1:0] in_red_level = '0, in_green_level = '0, in_blue_level = '0;
  logic out_empty, out_pop = 0;
  logic [POS_W-1:0] out_screen_col, out_screen_row;
  logic [IDX_W-1:0] out_palette_index;

  plot_scoreboard sb = new();
  bit  steady;        // no idling on either side
  bit  hold_request;  // asks the receiver for one long hold-off
  int  quiet_cycles, items_sent;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  rgb_to_palette_index_plotter_core u_top (.*);

  // receiver: random pops, plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop = 0;
      end else out_pop = steady || ($urandom_range(99) >= 29);
    end
  end

  // result monitor and stall watchdog
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      sb.check_plot(out_screen_col, out_screen_row, out_palette_index);
      quiet_cycles = 0;
    end else if ((in_push && !in_full) || (cfg_valid && cfg_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles > 5000) begin
      $display("timeout waiting for the core");
      $display("rgb_to_palette_index_plotter_core: mismatch");
      $finish;
    end
  end

  task send_pixel(int c, int r, int rl, int gl, int bl);
    while (!steady && $urandom_range(99) < 29) begin
      in_push = 0;
      @(negedge clk);
    end
    in_pixel_col = POS_W'(c); in_pixel_row = POS_W'(r);
    in_red_level = LVL_W'(rl); in_green_level = LVL_W'(gl);
    in_blue_level = LVL_W'(bl);
    in_push = 1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sb.note_pixel(in_pixel_col, in_pixel_row, in_red_level, in_green_level,
                  in_blue_level);
    items_sent++;
    @(negedge clk);
    in_push = 0;
  endtask

  // drain all owed plots, let dropped items clear the pipe, then write
  task write_config(int grey, int ic, int ir, int sc, int sr);
    logic [DIM_W-1:0] vals[5];
    vals = '{DIM_W'(grey), DIM_W'(ic), DIM_W'(ir), DIM_W'(sc), DIM_W'(sr)};
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    @(negedge clk);
    for (int i = REG_GREY_SELECT; i <= REG_SCREEN_ROWS; i++) begin
      cfg_index = 3'(i);
      cfg_data = vals[i];
      cfg_valid = 1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.write_reg(3'(i), vals[i]);
      @(negedge clk);
      cfg_valid = 0;
    end
  endtask

  // colour corners: black, white, saturated levels, primaries, max ties
  task directed_colours();
    send_pixel(0, 0, 0, 0, 0);
    send_pixel(1, 0, 4096, 4096, 4096);
    send_pixel(2, 0, 65535, 65535, 65535);
    send_pixel(3, 0, 4096, 0, 0);
    send_pixel(4, 0, 0, 4096, 0);
    send_pixel(5, 0, 0, 0, 4096);
    send_pixel(6, 0, 4096, 4096, 0);
    send_pixel(7, 0, 0, 4096, 4096);
    send_pixel(8, 0, 4096, 0, 4096);
    send_pixel(9, 0, 4096, 0, 40);
    send_pixel(10, 0, 4096, 3500, 3400);
    send_pixel(11, 0, 1000, 1000, 900);
    send_pixel(12, 0, 2200, 2100, 2050);
    send_pixel(13, 0, 3300, 3200, 3100);
    send_pixel(14, 0, 8, 7, 0);
    send_pixel(15, 0, 65535, 0, 65535);
    send_pixel(4095, 4095, 1800, 900, 2047);
    send_pixel(0, 1, 2040, 2056, 0);
  endtask

  // mostly scan lines with random colours, some loose pixels
  task random_pixels(int count, int ic, int ir);
    int c, r, cstep, rstep, rl, gl, bl;
    c = 0; r = 0;
    cstep = (ic > 64 && ic < 4096) ? ic / 12 : 400;
    rstep = (ir > 64 && ir < 4096) ? ir / 12 : 300;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(3))
        0: begin rl = $urandom_range(65535); gl = $urandom_range(65535);
                 bl = $urandom_range(65535); end
        1: begin rl = $urandom_range(4200); gl = rl; bl = $urandom_range(4200); end
        default: begin rl = $urandom_range(4200); gl = $urandom_range(4200);
                       bl = $urandom_range(4200); end
      endcase
      if ($urandom_range(99) < 12)
        send_pixel($urandom_range(4095), $urandom_range(4095), rl, gl, bl);
      else begin
        send_pixel(c, r, rl, gl, bl);
        c += $urandom_range(cstep, 1);
        if (c > 4095 || $urandom_range(99) < 8) begin
          c = 0;
          r += $urandom_range(rstep);
          if (r > 4095) r = 0;
        end
      end
    end
  endtask

  initial begin
    int setups[7][5];
    setups = '{'{1, 640, 480, 640, 480}, '{0, 4096, 4096, 640, 480},
               '{1, 100, 50, 4096, 4096}, '{0, 4096, 4096, 1, 1},
               '{0, 1, 1, 4096, 4096}, '{1, 0, 300, 8191, 0},
               '{0, 1000, 700, 640, 480}};
    sb.reset_state();
    repeat (4) @(negedge clk);
    rst_n = 1;
    // reset settings: colour mode, same-size image
    directed_colours();
    random_pixels(40, 640, 480);
    foreach (setups[p]) begin
      write_config(setups[p][0], setups[p][1], setups[p][2], setups[p][3],
                   setups[p][4]);
      steady = (p == 2);
      if (p == 0) directed_colours();
      if (p == 1) hold_request = 1;  // core fills while the receiver waits
      random_pixels(80, setups[p][1], setups[p][2]);
    end
    steady = 0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("sent %0d pixels over 8 settings, checked %0d plots, %0d dropped",
             items_sent, sb.checked, sb.dropped);
    if (sb.errors == 0) $display("rgb_to_palette_index_plotter_core: match");
    else $display("rgb_to_palette_index_plotter_core: mismatch");
    $finish;
  end
endmodule

### files.f
rtl/core/rtpi_pkg.sv
rtl/core/rtpi_front.sv
rtl/core/rtpi_queue.sv
rtl/core/rtpi_div.sv
rtl/core/rtpi_back.sv
rtl/core/rgb_to_palette_index_plotter_core.sv
bench/tb.sv
